/* rtl/rhc_pkg.sv */
// Shared types, constants and the divider step for the RGB/HSV converter.
package rhc_pkg;

  localparam logic [12:0] HueFull   = 13'd5760;
  localparam logic [9:0]  HueSector = 10'd960;
  localparam logic [12:0] SatOne    = 13'd4096;
  // 4096 * 960, the common denominator of the HSV mixing products
  localparam logic [21:0] MixDen    = 22'd3932160;
  // ceil(2^16 / 15), exact for dividends below 4096
  localparam logic [12:0] Recip15   = 13'd4370;

  typedef enum logic {
    OP_RGB2HSV = 1'b0,
    OP_HSV2RGB = 1'b1
  } op_e;

  // Word handed from the front to the back through the queue
  typedef struct packed {
    op_e         op;
    logic [7:0]  hi;
    logic [7:0]  span;
    logic [10:0] offs;
    logic [7:0]  bright;
    logic [12:0] sat;
    logic [9:0]  fr;
    logic [2:0]  k;
    logic        sat_zero;
  } qw_t;

  // One restoring-divide step result
  typedef struct packed {
    logic [7:0]  rem;
    logic [12:0] n;
    logic [12:0] q;
  } ds_t;

  function automatic ds_t div_step(logic [7:0] rem, logic [12:0] n, logic [12:0] q,
                                   logic [7:0] d);
    logic [8:0] t;
    logic [8:0] diff;
    logic       ge;
    ds_t        r;
    t      = {rem, n[12]};
    ge     = (t >= {1'b0, d});
    diff   = t - {1'b0, d};
    r.rem  = ge ? diff[7:0] : t[7:0];
    r.q    = {q[11:0], ge};
    r.n    = {n[11:0], 1'b0};
    return r;
  endfunction

endpackage

/* rtl/rhc_front.sv */
// Front end: classifies each pixel and works out sector data for the back end.
module rhc_front (
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic          op_i,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  input  logic [12:0]   hue_i,
  input  logic [12:0]   sat_i,
  input  logic [7:0]    value_i,
  output logic          q_wr_o,
  output rhc_pkg::qw_t  q_word_o,
  input  logic          q_full_i
);
  import rhc_pkg::*;

  logic [7:0]  hi, lo, span;
  logic [10:0] span6, offs;
  logic [12:0] hue_r, sect_base;
  logic [2:0]  k;
  logic [12:0] sat_c;

  assign s_ready_o = !q_full_i;
  assign q_wr_o    = s_valid_i && !q_full_i;

  // largest, smallest and hue offset in units of the spread
  always_comb begin
    hi = red_i;
    lo = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    span  = hi - lo;
    span6 = 11'(span) * 11'd6;
    if (red_i == hi) begin
      if (green_i >= blue_i) offs = 11'(green_i - blue_i);
      else offs = span6 - 11'(blue_i - green_i);
    end else if (green_i == hi) begin
      offs = (11'(span) << 1) + 11'(blue_i) - 11'(red_i);
    end else begin
      offs = (11'(span) << 2) + 11'(red_i) - 11'(green_i);
    end
  end

  // hue wrap, sector, saturation clamp
  always_comb begin
    hue_r = (hue_i >= HueFull) ? hue_i - HueFull : hue_i;
    sat_c = (sat_i > SatOne) ? SatOne : sat_i;
    if (hue_r >= 13'd4800) k = 3'd5;
    else if (hue_r >= 13'd3840) k = 3'd4;
    else if (hue_r >= 13'd2880) k = 3'd3;
    else if (hue_r >= 13'd1920) k = 3'd2;
    else if (hue_r >= 13'd960) k = 3'd1;
    else k = 3'd0;
    sect_base = 13'(k) * 13'(HueSector);
  end

  always_comb begin
    q_word_o.op       = op_e'(op_i);
    q_word_o.hi       = hi;
    q_word_o.span     = span;
    q_word_o.offs     = offs;
    q_word_o.bright   = value_i;
    q_word_o.sat      = sat_c;
    q_word_o.fr       = 10'(hue_r - sect_base);
    q_word_o.k        = k;
    q_word_o.sat_zero = (sat_c == 13'd0);
  end

endmodule

/* rtl/rhc_queue.sv */
// Two-entry queue between the front end and the back end.
module rhc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  rhc_pkg::qw_t  wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output rhc_pkg::qw_t  rdata_o
);
  import rhc_pkg::*;

  qw_t        mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= !wp_q;
      if (rd_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i || rd_i) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !rd_i) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

/* rtl/rhc_back.sv */
// Back end: pipelined dividers for RGB to HSV, mixing products for HSV to RGB.
module rhc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rhc_pkg::qw_t  q_word_i,
  output logic          q_rd_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic [12:0]   hue_o,
  output logic [12:0]   sat_o,
  output logic [7:0]    value_o,
  output logic          undef_o
);
  import rhc_pkg::*;

  localparam int unsigned NStage = 13;

  typedef struct packed {
    op_e         op;
    logic [7:0]  hi;
    logic [7:0]  span;
    logic [2:0]  k;
    logic [7:0]  bright;
    logic        sat_zero;
    logic [7:0]  rs;
    logic [12:0] ns;
    logic [12:0] qs;
    logic [7:0]  rh;
    logic [12:0] nh;
    logic [12:0] qh;
    logic [29:0] xp;
    logic [29:0] xq;
    logic [29:0] xt;
  } dv_t;

  logic        en;
  dv_t         a_q, a_d;
  logic        a_vld_q;
  dv_t         st_q [NStage];
  logic [NStage-1:0] vld_q;
  logic [20:0] nhue;

  // whole pipeline advances unless the output word is stalled
  assign en     = !m_valid_o || m_ready_i;
  assign q_rd_o = en && !q_empty_i;

  // entry stage: dividends and saturation products
  always_comb begin
    nhue         = 21'(q_word_i.offs) * 21'(HueSector);
    a_d.op       = q_word_i.op;
    a_d.hi       = q_word_i.hi;
    a_d.span     = q_word_i.span;
    a_d.k        = q_word_i.k;
    a_d.bright   = q_word_i.bright;
    a_d.sat_zero = q_word_i.sat_zero;
    a_d.rs       = {1'b0, q_word_i.span[7:1]};
    a_d.ns       = {q_word_i.span[0], 12'd0};
    a_d.qs       = 13'd0;
    a_d.rh       = nhue[20:13];
    a_d.nh       = nhue[12:0];
    a_d.qh       = 13'd0;
    a_d.xp       = 30'(q_word_i.sat * 23'(HueSector));
    a_d.xq       = 30'(q_word_i.sat * 23'(q_word_i.fr));
    a_d.xt       = 30'(q_word_i.sat * 23'(HueSector - q_word_i.fr));
  end

  always_ff @(posedge clk_i) begin
    if (en) a_q <= a_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      vld_q   <= '0;
    end else if (en) begin
      a_vld_q <= q_rd_o;
      vld_q   <= {vld_q[NStage-2:0], a_vld_q};
    end
  end

  // one quotient bit per stage; HSV products finish in the first two stages
  for (genvar i = 0; i < NStage; i++) begin : g_div
    dv_t src, nxt;
    ds_t s_step, h_step;
    logic [24:0] prod_p, prod_q, prod_t;
    if (i == 0) begin : g_src0
      assign src = a_q;
    end else begin : g_srcn
      assign src = st_q[i-1];
    end
    always_comb begin
      s_step = div_step(src.rs, src.ns, src.qs, src.hi);
      h_step = div_step(src.rh, src.nh, src.qh, src.span);
      prod_p = 25'(src.xp[29:18]) * 25'(Recip15);
      prod_q = 25'(src.xq[29:18]) * 25'(Recip15);
      prod_t = 25'(src.xt[29:18]) * 25'(Recip15);
      nxt    = src;
      nxt.rs = s_step.rem;
      nxt.ns = s_step.n;
      nxt.qs = s_step.q;
      nxt.rh = h_step.rem;
      nxt.nh = h_step.n;
      nxt.qh = h_step.q;
      if (i == 0) begin
        nxt.xp = 30'(src.bright) * 30'(MixDen - src.xp[21:0]);
        nxt.xq = 30'(src.bright) * 30'(MixDen - src.xq[21:0]);
        nxt.xt = 30'(src.bright) * 30'(MixDen - src.xt[21:0]);
      end else if (i == 1) begin
        nxt.xp = 30'(prod_p[23:16]);
        nxt.xq = 30'(prod_q[23:16]);
        nxt.xt = 30'(prod_t[23:16]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) st_q[i] <= nxt;
    end
  end

  // output register
  dv_t        fin;
  logic [7:0] pv, qv, tv, vv;
  assign fin = st_q[NStage-1];
  assign pv  = fin.xp[7:0];
  assign qv  = fin.xq[7:0];
  assign tv  = fin.xt[7:0];
  assign vv  = fin.bright;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_o <= 1'b0;
    end else if (en) begin
      m_valid_o <= vld_q[NStage-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_o   <= 8'd0;
      green_o <= 8'd0;
      blue_o  <= 8'd0;
      hue_o   <= 13'd0;
      sat_o   <= 13'd0;
      value_o <= 8'd0;
      undef_o <= 1'b0;
      if (fin.op == OP_RGB2HSV) begin
        value_o <= fin.hi;
        sat_o   <= (fin.hi == 8'd0) ? 13'd0 : fin.qs;
        hue_o   <= (fin.span == 8'd0) ? 13'd0 : fin.qh;
        undef_o <= (fin.span == 8'd0);
      end else if (fin.sat_zero) begin
        red_o   <= vv;
        green_o <= vv;
        blue_o  <= vv;
      end else begin
        case (fin.k)
          3'd0: begin red_o <= vv; green_o <= tv; blue_o <= pv; end
          3'd1: begin red_o <= qv; green_o <= vv; blue_o <= pv; end
          3'd2: begin red_o <= pv; green_o <= vv; blue_o <= tv; end
          3'd3: begin red_o <= pv; green_o <= qv; blue_o <= vv; end
          3'd4: begin red_o <= tv; green_o <= pv; blue_o <= vv; end
          default: begin red_o <= vv; green_o <= pv; blue_o <= qv; end
        endcase
      end
    end
  end

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o |-> sat_o <= SatOne) else $error("saturation above one");
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o |-> hue_o < HueFull) else $error("hue out of range");
  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && undef_o |-> hue_o == 13'd0 && sat_o == 13'd0)
    else $error("gray pixel with nonzero hue or saturation");

endmodule

/* rtl/rgb_hsv_convert_unit.sv */
// Top level of the RGB/HSV pixel converter.
// Usage:
//   One pixel per input word on the s_axis channel; tuser carries the
//   direction (0: RGB to HSV, 1: HSV to RGB), tdata the components.
//   One result word per pixel on the m_axis channel, in input order;
//   tuser there flags a gray RGB input whose hue is undefined.
// Throughput: one pixel per clock, sustained while m_axis_tready_i stays high.
// A pixel is written into the queue, then passes through the entry register
//   fed from the queue, the 13-stage restoring divider (one quotient bit per
//   stage) and the output register.
// A two-entry queue separates the classifying front end from the divider
//   pipeline; while a result waits, input flows on until the queue is full.
// When the receiver stalls, the whole back-end pipeline holds; the queue
//   then fills and s_axis_tready_o drops after at most two more words.
// Reset empties the queue and clears all valid bits; no results are
//   pending afterwards.
module rgb_hsv_convert_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // in_red, in_green, in_blue, in_hue, in_sat, in_value, zero fill
  input  logic [63:0] s_axis_tdata_i,
  // op
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_red, out_green, out_blue, out_hue, out_sat, out_value, zero fill
  output logic [63:0] m_axis_tdata_o,
  // hue_undefined
  output logic        m_axis_tuser_o
);
  import rhc_pkg::*;

  qw_t  wr_word, rd_word;
  logic q_wr, q_rd, q_full, q_empty;

  rhc_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .op_i      (s_axis_tuser_i),
    .red_i     (s_axis_tdata_i[7:0]),
    .green_i   (s_axis_tdata_i[15:8]),
    .blue_i    (s_axis_tdata_i[23:16]),
    .hue_i     (s_axis_tdata_i[36:24]),
    .sat_i     (s_axis_tdata_i[49:37]),
    .value_i   (s_axis_tdata_i[57:50]),
    .q_wr_o    (q_wr),
    .q_word_o  (wr_word),
    .q_full_i  (q_full)
  );

  rhc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (wr_word),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (rd_word)
  );

  rhc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_word_i  (rd_word),
    .q_rd_o    (q_rd),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .red_o     (m_axis_tdata_o[7:0]),
    .green_o   (m_axis_tdata_o[15:8]),
    .blue_o    (m_axis_tdata_o[23:16]),
    .hue_o     (m_axis_tdata_o[36:24]),
    .sat_o     (m_axis_tdata_o[49:37]),
    .value_o   (m_axis_tdata_o[57:50]),
    .undef_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o[63:58] = 6'd0;

endmodule
